// ----- rtl/tlpt_pkg.sv -----
// Shared types and codes for the two-level page table engine.
// No dependencies; used by every module of the block.
`default_nettype none
package tlpt_pkg;

  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_XLATE  = 2'd1;
  localparam logic [1:0] OP_UNMAP  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_NO_SLOT     = 2'd2;

  localparam int IDX_W   = 10;
  localparam int OFS_W   = 12;
  localparam int FRAME_W = 20;
  localparam int DIR_DEPTH = 1024;
  localparam int CNT_W   = 11;

  typedef enum logic [1:0] {
    K_MAP,
    K_XLATE,
    K_UNMAP,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_DIR,
    BS_PTE
  } be_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic        user_page;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] translated_address;
    logic        table_allocated;
    logic        table_released;
  } rsp_t;

  typedef struct packed {
    kind_t               kind;
    logic [IDX_W-1:0]    dir_idx;
    logic [IDX_W-1:0]    tbl_idx;
    logic [OFS_W-1:0]    offset;
    logic [FRAME_W-1:0]  frame;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage
`default_nettype wire

// ----- rtl/tlpt_front.sv -----
// Front end: accepts transactions, decodes them and queues them (two entries).
// Depends on tlpt_pkg.
`default_nettype none
module tlpt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire tlpt_pkg::req_t  req,
  input  wire logic            clearing,
  input  wire logic            pop,
  output tlpt_pkg::cmd_q_t     head
);

  tlpt_pkg::cmd_t fifo [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  tlpt_pkg::cmd_t dec;

  always_comb begin
    case (req.opcode)
      tlpt_pkg::OP_MAP:   dec.kind = tlpt_pkg::K_MAP;
      tlpt_pkg::OP_XLATE: dec.kind = tlpt_pkg::K_XLATE;
      tlpt_pkg::OP_UNMAP: dec.kind = tlpt_pkg::K_UNMAP;
      default:            dec.kind = tlpt_pkg::K_NOP;
    endcase
    dec.dir_idx = req.virtual_address[31:22];
    dec.tbl_idx = req.virtual_address[21:12];
    dec.offset  = req.virtual_address[11:0];
    dec.frame   = req.physical_address[31:12];
  end

  assign busy = clearing || (count == 2'd2);
  assign push = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tlpt_back.sv -----
// Back end: walks the directory and page table memories and writes results.
// Depends on tlpt_pkg.
`default_nettype none
module tlpt_back #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tlpt_pkg::cmd_q_t head,
  output logic                  pop,
  output logic                  clearing,
  output logic                  done,
  output tlpt_pkg::rsp_t        rsp
);

  localparam int SW        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PTE_DEPTH = TABLE_SLOTS * tlpt_pkg::DIR_DEPTH;
  localparam int PTE_AW    = $clog2(PTE_DEPTH);
  localparam int PW        = tlpt_pkg::FRAME_W + 1;

  tlpt_pkg::be_state_t state, state_next;
  tlpt_pkg::cmd_t      cmd;

  logic [SW:0]   dir_mem [0:tlpt_pkg::DIR_DEPTH-1];
  logic [PW-1:0] pte_mem [0:PTE_DEPTH-1];
  logic [SW:0]   dir_rd;
  logic [PW-1:0] pte_rd;

  logic [TABLE_SLOTS-1:0]     in_use;
  logic [tlpt_pkg::CNT_W-1:0] counts [0:TABLE_SLOTS-1];
  logic [SW-1:0]              slot, slot_next;
  logic                       alloc, alloc_next;
  logic [PTE_AW-1:0]          clr;

  logic [tlpt_pkg::IDX_W-1:0] dir_raddr, dir_waddr;
  logic [SW:0]                dir_wdata;
  logic                       dir_we;
  logic [PTE_AW-1:0]          pte_raddr, pte_waddr;
  logic [PW-1:0]              pte_wdata;
  logic                       pte_we;
  logic                       cnt_we;
  logic [tlpt_pkg::CNT_W-1:0] cnt_val, cnt;
  logic                       use_set, use_clr;
  logic                       rsp_load;
  tlpt_pkg::rsp_t             rsp_next;
  logic [SW-1:0]              free_idx;
  logic                       free_found;
  logic                       hit;

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign hit = dir_rd[SW];
  assign cnt = counts[slot];
  assign clearing = (state == tlpt_pkg::BS_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      tlpt_pkg::BS_CLEAR: if (clr == PTE_AW'(PTE_DEPTH - 1)) state_next = tlpt_pkg::BS_IDLE;
      tlpt_pkg::BS_IDLE:  if (head.valid) state_next = tlpt_pkg::BS_DIR;
      tlpt_pkg::BS_DIR: begin
        if (cmd.kind == tlpt_pkg::K_NOP) begin
          state_next = tlpt_pkg::BS_IDLE;
        end else if (hit || (cmd.kind == tlpt_pkg::K_MAP && free_found)) begin
          state_next = tlpt_pkg::BS_PTE;
        end else begin
          state_next = tlpt_pkg::BS_IDLE;
        end
      end
      tlpt_pkg::BS_PTE:   state_next = tlpt_pkg::BS_IDLE;
      default:            state_next = tlpt_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    dir_raddr  = head.cmd.dir_idx;
    dir_we     = 1'b0;
    dir_waddr  = cmd.dir_idx;
    dir_wdata  = '0;
    pte_we     = 1'b0;
    pte_waddr  = PTE_AW'({slot, cmd.tbl_idx});
    pte_wdata  = '0;
    slot_next  = slot;
    alloc_next = alloc;
    pte_raddr  = PTE_AW'({slot, cmd.tbl_idx});
    cnt_we     = 1'b0;
    cnt_val    = cnt;
    use_set    = 1'b0;
    use_clr    = 1'b0;
    rsp_load   = 1'b0;
    rsp_next   = '0;
    case (state)
      tlpt_pkg::BS_CLEAR: begin
        pte_we    = 1'b1;
        pte_waddr = clr;
        dir_we    = (32'(clr) < tlpt_pkg::DIR_DEPTH);
        dir_waddr = clr[tlpt_pkg::IDX_W-1:0];
      end
      tlpt_pkg::BS_IDLE: begin
        pop = head.valid;
      end
      tlpt_pkg::BS_DIR: begin
        alloc_next = 1'b0;
        slot_next  = dir_rd[SW-1:0];
        case (cmd.kind)
          tlpt_pkg::K_NOP: begin
            rsp_load = 1'b1;
          end
          tlpt_pkg::K_MAP: begin
            if (!hit) begin
              if (free_found) begin
                dir_we     = 1'b1;
                dir_wdata  = {1'b1, free_idx};
                use_set    = 1'b1;
                slot_next  = free_idx;
                alloc_next = 1'b1;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = tlpt_pkg::ST_NO_SLOT;
              end
            end
          end
          default: begin
            if (!hit) begin
              rsp_load        = 1'b1;
              rsp_next.status = tlpt_pkg::ST_NOT_PRESENT;
            end
          end
        endcase
        pte_raddr = PTE_AW'({slot_next, cmd.tbl_idx});
      end
      tlpt_pkg::BS_PTE: begin
        rsp_load = 1'b1;
        case (cmd.kind)
          tlpt_pkg::K_MAP: begin
            pte_we    = 1'b1;
            pte_wdata = {cmd.frame, 1'b1};
            if (!pte_rd[0]) begin
              cnt_we  = 1'b1;
              // a freshly allocated table starts its count from zero
              cnt_val = (alloc ? '0 : cnt) + 1'b1;
            end
            rsp_next.table_allocated = alloc;
          end
          tlpt_pkg::K_XLATE: begin
            if (pte_rd[0]) begin
              rsp_next.translated_address = {pte_rd[PW-1:1], cmd.offset};
            end else begin
              rsp_next.status = tlpt_pkg::ST_NOT_PRESENT;
            end
          end
          tlpt_pkg::K_UNMAP: begin
            if (pte_rd[0]) begin
              pte_we    = 1'b1;
              pte_wdata = {pte_rd[PW-1:1], 1'b0};
              cnt_we    = 1'b1;
              cnt_val   = (cnt != '0) ? cnt - 1'b1 : cnt;
              if (cnt <= tlpt_pkg::CNT_W'(1)) begin
                // last present entry gone: drop the table
                dir_we    = 1'b1;
                dir_wdata = {1'b0, slot};
                use_clr   = 1'b1;
                rsp_next.table_released = 1'b1;
              end
            end else begin
              rsp_next.status = tlpt_pkg::ST_NOT_PRESENT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dir_rd <= dir_mem[dir_raddr];
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
  end

  always_ff @(posedge clk) begin
    pte_rd <= pte_mem[pte_raddr];
    if (pte_we) pte_mem[pte_waddr] <= pte_wdata;
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= head.cmd;
    slot  <= slot_next;
    alloc <= alloc_next;
    if (rsp_load) rsp <= rsp_next;
    if (cnt_we) counts[slot] <= cnt_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tlpt_pkg::BS_CLEAR;
      clr    <= '0;
      in_use <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= rsp_load;
      if (clearing) clr <= clr + 1'b1;
      if (use_set) in_use[slot_next] <= 1'b1;
      if (use_clr) in_use[slot] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/two_level_page_table_engine_unit.sv -----
// Top level of the two-level page table engine: front end, queue, back end.
// Depends on tlpt_pkg, tlpt_front and tlpt_back.
//
// Map, translate and unmap transactions against an on-chip page directory
// (1024 entries) and TABLE_SLOTS page tables of 1024 entries each. A
// transaction is taken when start is high and busy is low; its result shows
// on rsp for exactly one cycle with done high, and the receiver cannot stall
// it. After reset the block clears both memories, one entry per cycle, and
// holds busy high until the clearing pass is over. After that a transaction
// that reaches the page table passes the back-end steps queue pop, directory
// read, and table entry read with write-back and result; a directory miss, a
// full slot pool or the unused opcode ends with its result after the
// directory read. The back end pops the next transaction only once the last
// one is finished, but a two-entry queue lets the host post the next
// transaction while one is in flight.
// Map takes the lowest free table slot when the directory entry is absent;
// status 2 if none is free. Unmap releases a table once it has no present
// entries. Opcode 3 gives status ok with all other fields zero.
`default_nettype none
module two_level_page_table_engine_unit #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire tlpt_pkg::req_t  req,
  output logic                 done,
  output tlpt_pkg::rsp_t       rsp
);

  tlpt_pkg::cmd_q_t head;
  logic             pop;
  logic             clearing;

  tlpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .clearing (clearing),
    .pop      (pop),
    .head     (head)
  );

  tlpt_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire

// ----- rtl/tlpt_checker.sv -----
// Port-level checks for the page table engine, bound to the top level.
// Depends on tlpt_pkg and two_level_page_table_engine_unit.
`default_nettype none
module tlpt_port_props (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           busy,
  input wire logic           done,
  input wire tlpt_pkg::rsp_t rsp
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("transaction port open during clearing pass");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != tlpt_pkg::ST_OK |->
      rsp.translated_address == 32'd0 && !rsp.table_allocated && !rsp.table_released)
    else $error("failed transaction carries data");

  a_alloc_rel_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.table_allocated && rsp.table_released))
    else $error("allocate and release together");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status <= tlpt_pkg::ST_NO_SLOT)
    else $error("undefined status code");

endmodule

bind two_level_page_table_engine_unit tlpt_port_props u_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire
